>>> rtl/ifla_pkg.sv
package ifla_pkg;

  // Port widths of the request, result and configuration fields.
  localparam int IDX_W = 10;
  localparam int CFG_W = 11;
  localparam int ST_W  = 2;

  // Pool size after reset.
  localparam int POOL_SIZE_RESET = 1024;

  // Request modes.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_USED = 2'd3;

endpackage

>>> rtl/index_free_list_allocator.sv
// Channel   Direction  Handshake            Fields
// request   in         start, busy          mode, item_index
// result    out        done (strobe)        status, out_index
// config    in         pool_size_we         pool_size
//
// Each request runs in steps: the accept edge reads the slot entry from the
// link memory, and the next edge decides, writes the entry back, moves the head
// and registers the result, which shows with done for one cycle.
// busy is high for the one cycle between those edges, so no new request is
// taken while one is in flight; the registered read of the link memory sets this,
// since the head that the next request reads from is moved only at the later edge.
// Reset, and any pool_size write, rebuilds the list at once through a fill mark:
// entries at or above the mark read as free and linked to the next slot.
// The receiver cannot stall; results are never held.
module index_free_list_allocator
  import ifla_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             mode,
  input  logic [IDX_W-1:0] item_index,
  output logic             done,
  output logic [ST_W-1:0]  status,
  output logic [IDX_W-1:0] out_index,
  input  logic             pool_size_we,
  input  logic [CFG_W-1:0] pool_size
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam int IW = (LW > IDX_W) ? LW : IDX_W;
  localparam int DW = LW + 1;
  localparam int POOL_RST = (POOL_SIZE_RESET > CAPACITY) ? CAPACITY : POOL_SIZE_RESET;

  logic [LW-1:0] pool;
  logic [LW-1:0] head;
  logic [LW-1:0] fill;
  logic          req_mode;
  logic [LW-1:0] req_addr;
  logic          req_range;
  logic          req_empty;

  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] cap_ext;
  logic [LW-1:0] pool_sat;
  logic [IW-1:0] idx_ext;
  logic          accept;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [DW-1:0] wr_data;
  logic          fresh;
  logic          ent_used;
  logic [LW-1:0] ent_link;
  logic [ST_W-1:0] st_next;

  // Saturate a written pool size to the capacity.
  assign cfg_ext  = CW'(pool_size);
  assign cap_ext  = CW'(CAPACITY);
  assign pool_sat = (cfg_ext > cap_ext) ? cap_ext[LW-1:0] : cfg_ext[LW-1:0];

  assign idx_ext = IW'(item_index);
  assign accept  = start && !busy;

  // Read the head entry on allocate, the named entry on release.
  assign rd_en   = accept;
  assign rd_addr = (mode == MODE_RELEASE) ? idx_ext[AW-1:0] : head[AW-1:0];

  // Entries at or above the fill mark were never written since the last rebuild.
  assign fresh    = req_addr >= fill;
  assign ent_used = fresh ? 1'b0 : rd_data[LW];
  assign ent_link = fresh ? req_addr + LW'(1) : rd_data[LW-1:0];

  // Decide the request and the entry write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = {1'b1, ent_link};
    st_next = ST_OK;
    if (req_mode == MODE_ALLOC) begin
      if (req_empty) begin
        st_next = ST_EMPTY;
      end else begin
        wr_en = busy;
      end
    end else begin
      wr_data = {1'b0, head};
      if (req_range) begin
        st_next = ST_RANGE;
      end else if (!ent_used) begin
        st_next = ST_NOT_USED;
      end else begin
        wr_en = busy;
      end
    end
  end

  ifla_link_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DW)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (req_addr[AW-1:0]),
    .wr_data (wr_data)
  );

  // Capture the request and its range checks at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_addr  <= (mode == MODE_RELEASE) ? idx_ext[LW-1:0] : head;
      req_range <= idx_ext >= IW'(pool);
      req_empty <= head >= pool;
    end
  end

  // Control state: pool size, list head, fill mark and handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= LW'(POOL_RST);
      head <= '0;
      fill <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy;
      busy <= accept;
      if (pool_size_we) begin
        pool <= pool_sat;
        head <= '0;
        fill <= '0;
      end else if (wr_en) begin
        if (req_mode == MODE_ALLOC) begin
          head <= ent_link;
          if (fresh) begin
            fill <= fill + LW'(1);
          end
        end else begin
          head <= req_addr;
        end
      end
    end
  end

  // Result registers, shown for one cycle with done.
  always_ff @(posedge clk) begin
    if (busy) begin
      status <= st_next;
      if (req_mode == MODE_ALLOC && st_next == ST_OK) begin
        out_index <= IDX_W'(req_addr);
      end else begin
        out_index <= '0;
      end
    end
  end

endmodule

>>> rtl/ifla_link_mem.sv
module ifla_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
